### hdl/avm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_pkg: shared types and constants of the voice mixer
// Buffer geometry, fixed-point limits, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package avm_pkg;

  localparam int CHUNK        = 32;
  localparam int MAX_CHANNELS = 2;
  localparam int BUF_DEPTH    = CHUNK * MAX_CHANNELS;
  localparam int BUF_W        = 18;
  localparam int ADDR_W       = $clog2(BUF_DEPTH);

  localparam logic [1:0]  OUT_CH_RESET = 2'd2;
  localparam logic        REG_OUT_CHANNELS = 1'b0;  // register index bit
  localparam logic [15:0] GAIN_ONE     = 16'd32768;
  localparam logic [15:0] OUT_MAX      = 16'd32767;
  localparam logic [15:0] DIV_K        = 16'd32767;  // 131068 / 4
  localparam logic signed [19:0] W_MAX = 20'sd131071;
  localparam logic signed [19:0] W_MIN = -20'sd131072;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_READ,
    S_MUL,
    S_WRITE,
    S_DREAD,
    S_DLOAD
  } avm_state_e;

  typedef struct packed {
    logic latch;      // capture input item
    logic scale_en;   // register gain-scaled samples
    logic rd_en;      // issue buffer read for current step
    logic mul_en;     // register |a|*|b|
    logic wr_en;      // write mixed value back
    logic out_load;   // load output register from read data
    logic row_clear;  // invalidate both channels of the slot
    logic step;       // channel step 0 or 1
  } avm_cmd_t;

  typedef struct packed {
    logic two_steps;  // add item touches two steps
    logic oc_two;     // two output channels
    logic out_free;   // output register can take a result
  } avm_status_t;

  function automatic logic [BUF_W-1:0] mag18(input logic [BUF_W-1:0] v);
    mag18 = v[BUF_W-1] ? (~v + 18'd1) : v;
  endfunction

endpackage

### hdl/audio_voice_mixer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_voice_mixer_top: nonlinear voice mixer over a one-chunk buffer
// Usage:
//   Input channel (in_valid_i / in_stall_o): opcode 0 adds one voice frame
//   into slot frame_slot_i, opcode 1 drains that slot. A transfer occurs
//   when valid is high and stall is low.
//   Output channel (out_valid_o / out_stall_i): a drain yields one transfer
//   per output channel, channel 0 first, last_o on the final one.
//   APB port: register 0 (byte address 0) is out_channels, reset 2.
//   Sequencing: an add keeps the input stalled after its transfer while it
//   reads, multiplies and writes each buffer entry that it touches, one or
//   two, through the one RAM port. A drain reads each output channel's
//   entry and then loads it into the output register, one channel after
//   the other.
//   A result waiting in the output register does not block new items; a
//   stalled receiver holds off the next result load, and the input stays
//   stalled while a drain waits on it.
//   Reset clears all entry valid bits, so the buffer reads as zero right
//   away; no clearing pass is run.
// ----------------------------------------------------------------------------
module audio_voice_mixer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [4:0]         frame_slot_i,
  input  logic [1:0]         voice_channels_i,
  input  logic signed [15:0] sample_first_i,
  input  logic signed [15:0] sample_second_i,
  input  logic [15:0]        gain_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         out_frame_o,
  output logic               out_chan_o,
  output logic signed [15:0] out_sample_o,
  output logic               last_o,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import avm_pkg::*;

  // out_channels register; write decode looks at the word index bit only
  logic [1:0] oc_q, oc_d;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_OUT_CHANNELS);

  always_comb begin
    oc_d = oc_q;
    if (cfg_wr) begin
      oc_d = pwdata[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q <= OUT_CH_RESET;
    end else begin
      oc_q <= oc_d;
    end
  end

  assign prdata = (paddr[2] == REG_OUT_CHANNELS) ? {30'b0, oc_q} : 32'b0;

  // zero acts as one and three as two: the upper bit alone says "stereo"
  avm_cmd_t    cmd;
  avm_status_t status;

  avm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  avm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .oc_two_i         (oc_q[1]),
    .opcode_i         (opcode_i),
    .frame_slot_i     (frame_slot_i),
    .voice_channels_i (voice_channels_i),
    .sample_first_i   (sample_first_i),
    .sample_second_i  (sample_second_i),
    .gain_i           (gain_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_frame_o      (out_frame_o),
    .out_chan_o       (out_chan_o),
    .out_sample_o     (out_sample_o),
    .last_o           (last_o)
  );

`ifndef ASSERT_OFF
  // an accepted item always keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block ready right after accepting an item");

  // write-back only follows the multiply stage
  a_write_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> $past(cmd.mul_en))
    else $error("buffer write without preceding multiply");

  // slot is invalidated only together with its final result load
  a_clear_with_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.row_clear |-> cmd.out_load && !cmd.wr_en)
    else $error("row cleared outside final drain load");
`endif

endmodule

### hdl/avm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module avm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/avm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_ctrl: sequencer of the voice mixer
// Steps add items through scale / read / multiply / write and drain
// items through read / load for each channel.
// ----------------------------------------------------------------------------
module avm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  input  avm_pkg::avm_status_t status_i,
  output logic                 in_stall_o,
  output avm_pkg::avm_cmd_t    cmd_o
);
  import avm_pkg::*;

  avm_state_e state_q, state_d;
  logic       step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        step_d     = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = opcode_i ? S_DREAD : S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale_en = 1'b1;
        cmd_o.rd_en    = 1'b1;
        state_d        = S_MUL;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        if (!step_q && status_i.two_steps) begin
          step_d  = 1'b1;
          state_d = S_READ;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DREAD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_DLOAD;
      end
      S_DLOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (!step_q && status_i.oc_two) begin
            step_d  = 1'b1;
            state_d = S_DREAD;
          end else begin
            cmd_o.row_clear = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### hdl/avm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_datapath: arithmetic and storage of the voice mixer
// Gain scaling, nonlinear pair mix, buffer RAM with valid bits and the
// output register.
// ----------------------------------------------------------------------------
module avm_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  avm_pkg::avm_cmd_t    cmd_i,
  output avm_pkg::avm_status_t status_o,
  input  logic                 oc_two_i,
  input  logic                 opcode_i,
  input  logic [4:0]           frame_slot_i,
  input  logic [1:0]           voice_channels_i,
  input  logic signed [15:0]   sample_first_i,
  input  logic signed [15:0]   sample_second_i,
  input  logic [15:0]          gain_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [4:0]           out_frame_o,
  output logic                 out_chan_o,
  output logic signed [15:0]   out_sample_o,
  output logic                 last_o
);
  import avm_pkg::*;

  // latched item
  logic              drain_q;
  logic [4:0]        slot_q;
  logic              vc_two_q;
  logic [15:0]       s0_q, s1_q, gain_q;

  // scaled samples, mix operands
  logic [BUF_W-1:0]  v0_q, v1_q, a_q, b_q;
  logic [35:0]       prod_q;
  logic [ADDR_W-1:0] addr_q;
  logic              vld_rd_q;
  logic [BUF_DEPTH-1:0] vld_q, vld_d;

  logic              out_valid_q, out_valid_d;
  logic [4:0]        out_frame_q;
  logic              out_chan_q, last_q;
  logic [15:0]       out_sample_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      drain_q  <= opcode_i;
      slot_q   <= frame_slot_i;
      vc_two_q <= voice_channels_i[1];
      s0_q     <= sample_first_i;
      s1_q     <= sample_second_i;
      gain_q   <= gain_i;
    end
  end

  // gain scaling: trunc(|s| * g / 8192) with sign restored
  function automatic logic [BUF_W-1:0] scale(input logic [15:0] s, input logic [15:0] g);
    logic [16:0] s17, mag;
    logic [32:0] p;
    logic [BUF_W-1:0] sh;
    s17 = {s[15], s};
    mag = s17[16] ? (~s17 + 17'd1) : s17;
    p   = 33'(mag) * 33'(g);
    sh  = p[30:13];
    scale = s[15] ? (18'd0 - sh) : sh;
  endfunction

  logic [15:0] gain_c;
  assign gain_c = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      v0_q <= scale(s0_q, gain_c);
      v1_q <= scale(s1_q, gain_c);
    end
  end

  // buffer addressing
  logic              ch;
  logic [ADDR_W-1:0] raddr;
  assign ch    = drain_q ? cmd_i.step : (cmd_i.step & oc_two_i);
  assign raddr = {slot_q, ch};

  logic [BUF_W-1:0] rdata, wdata, a_cur;
  assign a_cur = vld_rd_q ? rdata : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      addr_q   <= raddr;
      vld_rd_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      a_q    <= a_cur;
      b_q    <= (cmd_i.step & vc_two_q) ? v1_q : v0_q;
      prod_q <= 36'(mag18(a_cur)) * 36'(mag18((cmd_i.step & vc_two_q) ? v1_q : v0_q));
    end
  end

  // correction = floor(prod / 131068) = floor((prod >> 2) / 32767)
  logic [32:0]      quo;
  logic [17:0]      q0, corr;
  logic [18:0]      r1;
  logic [3:0]       q1;
  logic [15:0]      r2;
  logic             adj, a_pos, b_pos, a_neg, b_neg;
  logic signed [19:0] sum;

  always_comb begin
    quo  = prod_q[34:2];
    q0   = quo[32:15];
    r1   = {4'b0, quo[14:0]} + {1'b0, q0};
    q1   = r1[18:15];
    r2   = {1'b0, r1[14:0]} + {12'b0, q1};
    adj  = (r2 >= DIV_K);
    corr = q0 + 18'(q1) + 18'(adj);
    a_neg = a_q[BUF_W-1];
    b_neg = b_q[BUF_W-1];
    a_pos = !a_neg && (a_q != '0);
    b_pos = !b_neg && (b_q != '0);
    sum  = $signed({{2{a_q[BUF_W-1]}}, a_q}) + $signed({{2{b_q[BUF_W-1]}}, b_q});
    if (a_pos && b_pos) begin
      sum = sum - $signed({2'b0, corr});
    end else if (a_neg && b_neg) begin
      sum = sum + $signed({2'b0, corr});
    end
    if (sum > W_MAX) begin
      wdata = W_MAX[BUF_W-1:0];
    end else if (sum < W_MIN) begin
      wdata = W_MIN[BUF_W-1:0];
    end else begin
      wdata = sum[BUF_W-1:0];
    end
  end

  avm_ram #(
    .WIDTH (BUF_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // valid bits: unwritten or drained entries read as zero
  always_comb begin
    vld_d = vld_q;
    if (cmd_i.wr_en) begin
      vld_d[addr_q] = 1'b1;
    end
    if (cmd_i.row_clear) begin
      vld_d[{slot_q, 1'b0}] = 1'b0;
      vld_d[{slot_q, 1'b1}] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // output conversion: trunc(w / 4) saturated to +-32767
  logic [BUF_W-1:0] w_mag;
  logic [15:0]      m, mc;
  always_comb begin
    w_mag = mag18(a_cur);
    m     = w_mag[17:2];
    mc    = (m > OUT_MAX) ? OUT_MAX : m;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_frame_q  <= slot_q;
      out_chan_q   <= cmd_i.step;
      out_sample_q <= a_cur[BUF_W-1] ? (16'd0 - mc) : mc;
      last_q       <= cmd_i.step | ~oc_two_i;
    end
  end

  assign status_o.two_steps = vc_two_q | oc_two_i;
  assign status_o.oc_two    = oc_two_i;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign out_frame_o  = out_frame_q;
  assign out_chan_o   = out_chan_q;
  assign out_sample_o = out_sample_q;
  assign last_o       = last_q;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for audio_voice_mixer_top
// Drives add/drain frames over the valid/stall input channel, keeps a
// shadow of the mix buffer to predict every drained sample, and checks
// each output transfer field by field. Both sides idle at random; the
// out_channels register is changed over APB between phases.
// ----------------------------------------------------------------------------
module tb;

  // opcodes of an input item
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // APB byte address of out_channels
  localparam logic [2:0] OUT_CH_ADDR = 3'(4 * avm_pkg::REG_OUT_CHANNELS);

  // Q1.15 gain of one, buffer scale and limits
  localparam int GAIN_UNITY = 32768;
  localparam int MIX_ONE    = 131068;
  localparam int MIX_HI     = 131071;
  localparam int MIX_LO     = -131072;
  localparam int PCM_HI     = 32767;

  localparam int SETTLE_CYCLES = 16;   // outlasts the longest add
  localparam int STUCK_LIMIT   = 2000; // cycles with no transfer at all
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 66;

  typedef struct {
    logic               op;
    logic [4:0]         slot;
    logic [1:0]         vch;
    logic signed [15:0] s0;
    logic signed [15:0] s1;
    logic [15:0]        gain;
  } voice_item_t;

  typedef struct {
    logic [4:0]         frame;
    logic               chan;
    logic signed [15:0] sample;
    logic               last;
  } pcm_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  logic               opcode_i         = OP_ADD;
  logic [4:0]         frame_slot_i     = '0;
  logic [1:0]         voice_channels_i = '0;
  logic signed [15:0] sample_first_i   = '0;
  logic signed [15:0] sample_second_i  = '0;
  logic [15:0]        gain_i           = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  logic [4:0]         out_frame_o;
  logic               out_chan_o;
  logic signed [15:0] out_sample_o;
  logic               last_o;
  logic               psel             = 1'b0;
  logic               penable          = 1'b0;
  logic               pwrite           = 1'b0;
  logic [2:0]         paddr            = '0;
  logic [31:0]        pwdata           = '0;
  logic [31:0]        prdata;
  logic               pready;

  audio_voice_mixer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .frame_slot_i     (frame_slot_i),
    .voice_channels_i (voice_channels_i),
    .sample_first_i   (sample_first_i),
    .sample_second_i  (sample_second_i),
    .gain_i           (gain_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_frame_o      (out_frame_o),
    .out_chan_o       (out_chan_o),
    .out_sample_o     (out_sample_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the mixer
  // --------------------------------------------------------------------------
  int          shadow_mix [avm_pkg::BUF_DEPTH];
  logic [1:0]  cfg_out_ch = avm_pkg::OUT_CH_RESET;

  voice_item_t pending_voice_q [$];   // frames waiting to be driven
  pcm_result_t drained_pcm_q   [$];   // samples a drain must still return

  int unsigned mismatch_cnt = 0;
  bit          tx_idle_en   = 1'b0;   // sender gaps on/off per phase
  bit          rx_idle_en   = 1'b0;   // receiver stalls on/off per phase

  initial begin
    foreach (shadow_mix[i]) shadow_mix[i] = 0;
  end

  // channel count 0 acts as 1, anything above the max as the max
  function automatic int unsigned lanes(input logic [1:0] n);
    if (n == 2'd0) return 1;
    if (n > avm_pkg::MAX_CHANNELS) return avm_pkg::MAX_CHANNELS;
    return 32'(n);
  endfunction

  // |s| * gain / 8192 truncated toward zero; gain saturates at one
  function automatic int apply_gain(input logic signed [15:0] s, input logic [15:0] g);
    longint mag;
    longint gl;
    longint r;
    gl  = (g > GAIN_UNITY) ? longint'(GAIN_UNITY) : longint'(g);
    mag = (s < 0) ? -longint'(s) : longint'(s);
    r   = (mag * gl) >> 13;
    return (s < 0) ? -int'(r) : int'(r);
  endfunction

  // nonlinear sum: same-sign operands get the |a||b| correction
  function automatic int soft_mix(input int a, input int b);
    longint ma;
    longint mb;
    longint corr;
    longint r;
    ma   = (a < 0) ? -longint'(a) : longint'(a);
    mb   = (b < 0) ? -longint'(b) : longint'(b);
    corr = (ma * mb) / MIX_ONE;
    r    = longint'(a) + longint'(b);
    if (a > 0 && b > 0) r -= corr;
    else if (a < 0 && b < 0) r += corr;
    if (r > MIX_HI) r = MIX_HI;
    if (r < MIX_LO) r = MIX_LO;
    return int'(r);
  endfunction

  // buffer units back to Q1.15, truncated toward zero and saturated
  function automatic logic signed [15:0] to_pcm(input int w);
    int m;
    m = ((w < 0) ? -w : w) >>> 2;
    if (m > PCM_HI) m = PCM_HI;
    return (w < 0) ? 16'(-m) : 16'(m);
  endfunction

  // apply one accepted frame to the shadow buffer, queue drained samples
  function automatic void mix_frame(input voice_item_t it);
    int unsigned vc;
    int unsigned oc;
    int unsigned base;
    int unsigned ic;
    int unsigned oidx;
    int unsigned k;
    int          v [2];
    pcm_result_t r;
    base = (it.slot % avm_pkg::CHUNK) * avm_pkg::MAX_CHANNELS;
    oc   = lanes(cfg_out_ch);
    if (it.op == OP_ADD) begin
      vc   = lanes(it.vch);
      v[0] = apply_gain(it.s0, it.gain);
      v[1] = apply_gain(it.s1, it.gain);
      for (k = 0; k < vc || k < oc; k++) begin
        ic   = (k < vc) ? k : vc - 1;
        oidx = (k < oc) ? k : oc - 1;
        shadow_mix[base + oidx] = soft_mix(shadow_mix[base + oidx], v[ic & 1]);
      end
    end else begin
      for (k = 0; k < oc; k++) begin
        r.frame  = it.slot;
        r.chan   = k[0];
        r.sample = to_pcm(shadow_mix[base + k]);
        r.last   = (k + 1 == oc);
        drained_pcm_q = {drained_pcm_q, r};
      end
      for (k = 0; k < avm_pkg::MAX_CHANNELS; k++) shadow_mix[base + k] = 0;
    end
  endfunction

  function automatic int unsigned idle_draw(input bit en);
    return en ? $urandom_range(0, 17) : 0;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued frames, holds them while stalled, then waits
  // the drawn gap before the next one. Prediction happens on the transfer.
  // --------------------------------------------------------------------------
  voice_item_t tx_cur;
  int unsigned tx_gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      tx_gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        mix_frame(tx_cur);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
          in_valid_i  <= 1'b0;
        end else if (pending_voice_q.size() != 0) begin
          tx_cur            = pending_voice_q[0];
          pending_voice_q.delete(0);
          opcode_i         <= tx_cur.op;
          frame_slot_i     <= tx_cur.slot;
          voice_channels_i <= tx_cur.vch;
          sample_first_i   <= tx_cur.s0;
          sample_second_i  <= tx_cur.s1;
          gain_i           <= tx_cur.gain;
          in_valid_i       <= 1'b1;
          tx_gap_left      <= idle_draw(tx_idle_en);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls each result for a drawn number of valid cycles, then
  // checks the transfer against the oldest predicted sample.
  // --------------------------------------------------------------------------
  pcm_result_t rx_want;
  int unsigned rx_hold;
  int unsigned rx_stall_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      rx_stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (drained_pcm_q.size() == 0) begin
        $error("unexpected result: frame %0d channel %0d sample %0d",
               out_frame_o, out_chan_o, out_sample_o);
        mismatch_cnt++;
      end else begin
        rx_want = drained_pcm_q[0];
        drained_pcm_q.delete(0);
        if (out_frame_o !== rx_want.frame) begin
          $error("out_frame: expected %0d, got %0d", rx_want.frame, out_frame_o);
          mismatch_cnt++;
        end
        if (out_chan_o !== rx_want.chan) begin
          $error("out_chan: expected %0d, got %0d", rx_want.chan, out_chan_o);
          mismatch_cnt++;
        end
        if (out_sample_o !== rx_want.sample) begin
          $error("out_sample: expected %0d, got %0d", rx_want.sample, out_sample_o);
          mismatch_cnt++;
        end
        if (last_o !== rx_want.last) begin
          $error("last: expected %0d, got %0d", rx_want.last, last_o);
          mismatch_cnt++;
        end
      end
      rx_hold        = idle_draw(rx_idle_en);
      rx_stall_left <= rx_hold;
      out_stall_i   <= (rx_hold != 0);
    end else if (out_valid_o && rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_stall_i   <= (rx_stall_left > 1);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any transfer on either channel or APB restarts the count
  // --------------------------------------------------------------------------
  int unsigned stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_frame(input logic op, input logic [4:0] slot,
                                      input logic [1:0] vch, input int s0, input int s1,
                                      input int gain);
    voice_item_t it;
    it.op   = op;
    it.slot = slot;
    it.vch  = vch;
    it.s0   = 16'(s0);
    it.s1   = 16'(s1);
    it.gain = 16'(gain);
    pending_voice_q = {pending_voice_q, it};
  endfunction

  // extremes and zero show up often so the saturation paths get hit
  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly adds into a few hot slots so frames pile up several voices
  // before a drain; now and then any slot
  function automatic voice_item_t random_frame();
    voice_item_t it;
    it.op   = ($urandom_range(0, 3) == 0) ? OP_DRAIN : OP_ADD;
    it.slot = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, 3));
    it.vch  = 2'($urandom_range(0, 3));
    it.s0   = random_sample();
    it.s1   = random_sample();
    case ($urandom_range(0, 7))
      0:       it.gain = 16'(GAIN_UNITY);
      1:       it.gain = 16'($urandom_range(GAIN_UNITY + 1, 65535));
      2:       it.gain = '0;
      default: it.gain = 16'($urandom_range(0, GAIN_UNITY));
    endcase
    return it;
  endfunction

  // write out_channels, then read it back
  task automatic write_out_channels(input logic [1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= OUT_CH_ADDR;
    pwdata  <= {30'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_out_ch = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {30'd0, val}) begin
      $error("prdata: expected %0d, got %0d", val, prdata);
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // wait until every frame is taken and every sample is back, then let an
  // add that yields nothing finish its buffer write
  task automatic settle();
    while (pending_voice_q.size() != 0 || in_valid_i || drained_pcm_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [1:0] phase_cfg [RAND_PHASES] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd2};

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, out_channels at its reset value
    queue_frame(OP_DRAIN, 0, 2, 0, 0, 0);                    // drain of a clean slot
    queue_frame(OP_ADD, 1, 2, 32767, -32768, GAIN_UNITY);
    queue_frame(OP_ADD, 1, 2, 32767, -32768, GAIN_UNITY);    // both-positive / both-negative
    queue_frame(OP_DRAIN, 1, 2, 0, 0, 0);
    queue_frame(OP_ADD, 2, 1, -20000, 777, 65535);           // mono, gain above one
    queue_frame(OP_ADD, 2, 0, 12345, -5, 16384);             // zero channel count
    queue_frame(OP_ADD, 2, 3, -1, 1, GAIN_UNITY);            // channel count too large
    queue_frame(OP_DRAIN, 2, 2, 0, 0, 0);
    queue_frame(OP_ADD, 3, 2, 0, 0, GAIN_UNITY);             // zero operands
    queue_frame(OP_ADD, 3, 2, 1000, -1000, GAIN_UNITY);
    queue_frame(OP_ADD, 3, 2, -3000, 3000, 20000);           // mixed signs
    queue_frame(OP_ADD, 3, 2, 0, 0, 0);
    queue_frame(OP_DRAIN, 3, 2, 0, 0, 0);
    queue_frame(OP_ADD, 31, 2, -32768, 32767, 0);
    queue_frame(OP_ADD, 31, 2, -32768, -32768, 1);
    queue_frame(OP_DRAIN, 31, 2, 0, 0, 0);
    queue_frame(OP_DRAIN, 31, 2, 0, 0, 0);                   // already cleared
    settle();

    // random phases; each boundary waits for every frame and sample before the next write
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_out_channels(phase_cfg[p]);
      tx_idle_en = (p != 1);
      rx_idle_en = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) pending_voice_q = {pending_voice_q, random_frame()};
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### audio_voice_mixer_top.f
hdl/avm_pkg.sv
hdl/avm_ram.sv
hdl/avm_ctrl.sv
hdl/avm_datapath.sv
hdl/audio_voice_mixer_top.sv
tb/sv/tb.sv
